/* design/mhpq_pkg.sv */
package mhpq_pkg;

    // Heap geometry and key width.
    localparam int DEPTH     = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CHILD_W   = ADDR_W + 1;

    // Fixed field widths of the request and response.
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    // Operation codes.
    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_POP   = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [KEY_WIDTH-1:0] t_key;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [VALUE_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [VALUE_W-1:0] top_value;
        logic                      top_valid;
        logic [COUNT_W-1:0]        entry_count;
    } t_rsp;

    // Sign-extend the request value, then cut it to the key width.
    function automatic t_key to_key(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[KEY_WIDTH-1:0];
    endfunction

    // Sign-extend a key, then cut it to the response value width.
    function automatic logic signed [VALUE_W-1:0] from_key(input t_key k);
        logic signed [63:0] ext;
        ext = 64'(k);
        return ext[VALUE_W-1:0];
    endfunction

endpackage

/* design/mhpq_ram.sv */
module mhpq_ram #(
    parameter int DEPTH_P = 64,
    parameter int WIDTH_P = 32
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH_P)-1:0] i_waddr,
    input  logic [WIDTH_P-1:0]         i_wdata,
    input  logic [$clog2(DEPTH_P)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH_P)-1:0] i_raddr_b,
    output logic [WIDTH_P-1:0]         o_rdata_a,
    output logic [WIDTH_P-1:0]         o_rdata_b
);

    // One write port and two registered read ports.
    logic [WIDTH_P-1:0] r_mem [DEPTH_P];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/min_heap_priority_queue.sv */
// Binary min-heap priority queue of signed keys. A request is taken when
// i_start is high while o_busy is low; it pushes a key, pops the minimum or
// clears the heap. Exactly one response follows, shown on o_rsp for a single
// cycle while o_done is high, and it must be captured in that cycle because
// the receiver cannot stall it. The response carries the status (done, push
// refused because full, pop refused because empty), the smallest key left,
// a non-empty flag and the entry count. A clear, a refused request, a push
// into an empty heap or a pop of the last entry answer in the cycle after
// acceptance. A pop that leaves one entry fetches the last entry and then
// writes it to the root. Any other push lifts the key one level at a time
// toward the root; any other pop fetches the last entry, then sinks it one
// level at a time. The pace is set by the heap memory: one registered read
// (two for the two children of a pop) and one compare per level. A new
// request may be given in the cycle that carries the previous response.
module min_heap_priority_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  mhpq_pkg::t_req   i_req,
    output logic             o_busy,
    output logic             o_done,
    output mhpq_pkg::t_rsp   o_rsp
);

    import mhpq_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_POP_LD = 3'd2;
    localparam logic [2:0] S_DN     = 3'd3;
    localparam logic [2:0] S_FIN    = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [CHILD_W-1:0] r_child, n_child;
    t_key               r_t, n_t;
    t_key               r_top;
    logic               r_done, n_done;
    logic [1:0]         r_status, n_status;

    // Memory port controls.
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    t_key               wdata;
    logic [ADDR_W-1:0]  raddr_a, raddr_b;
    t_key               rdata_a, rdata_b;

    mhpq_ram #(
        .DEPTH_P (DEPTH),
        .WIDTH_P (KEY_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    logic               accept;
    logic [ADDR_W-1:0]  pos_m1;
    logic [ADDR_W-1:0]  up_parent;
    logic [ADDR_W-1:0]  cnt_low;
    logic               use_b;
    logic [CHILD_W-1:0] pick;
    t_key               pick_val;
    logic [CHILD_W-1:0] next_child;

    assign accept  = i_start && (r_state == S_IDLE);
    assign cnt_low = r_cnt[ADDR_W-1:0];
    // Parent of the current climbing slot.
    assign pos_m1    = r_pos - ADDR_W'(1);
    assign up_parent = pos_m1 >> 1;

    // Child selection for the sinking key: the right child wins only when
    // it exists and is strictly smaller than the left one.
    assign use_b      = ((r_child + CHILD_W'(1)) < CHILD_W'(r_cnt)) && (rdata_a > rdata_b);
    assign pick       = use_b ? (r_child + CHILD_W'(1)) : r_child;
    assign pick_val   = use_b ? rdata_b : rdata_a;
    assign next_child = {pick[ADDR_W-1:0], 1'b1};

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_child  = r_child;
        n_t      = r_t;
        n_done   = 1'b0;
        n_status = r_status;
        we       = 1'b0;
        waddr    = r_pos;
        wdata    = r_t;
        raddr_a  = r_child[ADDR_W-1:0];
        raddr_b  = r_child[ADDR_W-1:0] + ADDR_W'(1);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.mode)
                        MODE_PUSH: begin
                            if (r_cnt == CNT_W'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_done   = 1'b1;
                            end else begin
                                n_status = ST_DONE;
                                n_cnt    = r_cnt + CNT_W'(1);
                                n_t      = to_key(i_req.value);
                                n_pos    = cnt_low;
                                if (r_cnt == '0) begin
                                    // First entry lands straight at the root.
                                    we     = 1'b1;
                                    waddr  = '0;
                                    wdata  = to_key(i_req.value);
                                    n_done = 1'b1;
                                end else begin
                                    raddr_a = (cnt_low - ADDR_W'(1)) >> 1;
                                    n_state = S_UP;
                                end
                            end
                        end
                        MODE_POP: begin
                            if (r_cnt == '0) begin
                                n_status = ST_EMPTY;
                                n_done   = 1'b1;
                            end else begin
                                n_status = ST_DONE;
                                n_cnt    = r_cnt - CNT_W'(1);
                                if (r_cnt == CNT_W'(1)) begin
                                    n_done = 1'b1;
                                end else begin
                                    // Fetch the last entry; it moves to the root.
                                    raddr_a = cnt_low - ADDR_W'(1);
                                    n_state = S_POP_LD;
                                end
                            end
                        end
                        MODE_CLEAR: begin
                            n_status = ST_DONE;
                            n_cnt    = '0;
                            n_done   = 1'b1;
                        end
                        default: begin
                            n_status = ST_DONE;
                            n_done   = 1'b1;
                        end
                    endcase
                end
            end

            S_UP: begin
                // rdata_a holds the parent of r_pos.
                if (r_t > rdata_a) begin
                    we      = 1'b1;
                    waddr   = r_pos;
                    wdata   = r_t;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    we    = 1'b1;
                    waddr = r_pos;
                    wdata = rdata_a;
                    n_pos = up_parent;
                    if (up_parent == '0) begin
                        n_state = S_FIN;
                    end else begin
                        raddr_a = (up_parent - ADDR_W'(1)) >> 1;
                    end
                end
            end

            S_POP_LD: begin
                n_t   = rdata_a;
                n_pos = '0;
                if (r_cnt == CNT_W'(1)) begin
                    we      = 1'b1;
                    waddr   = '0;
                    wdata   = rdata_a;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_child = CHILD_W'(1);
                    raddr_a = ADDR_W'(1);
                    raddr_b = ADDR_W'(2);
                    n_state = S_DN;
                end
            end

            S_DN: begin
                if (r_t > pick_val) begin
                    we      = 1'b1;
                    waddr   = r_pos;
                    wdata   = pick_val;
                    n_pos   = pick[ADDR_W-1:0];
                    n_child = next_child;
                    if (next_child < CHILD_W'(r_cnt)) begin
                        raddr_a = next_child[ADDR_W-1:0];
                        raddr_b = next_child[ADDR_W-1:0] + ADDR_W'(1);
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    we      = 1'b1;
                    waddr   = r_pos;
                    wdata   = r_t;
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_FIN: begin
                we      = 1'b1;
                waddr   = r_pos;
                wdata   = r_t;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_done   <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    // Working registers; the root is mirrored so the response needs no read.
    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_child <= n_child;
        r_t     <= n_t;
        if (we && (waddr == '0)) begin
            r_top <= wdata;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    always_comb begin
        o_rsp.status      = r_status;
        o_rsp.top_valid   = (r_cnt != '0);
        o_rsp.top_value   = (r_cnt != '0) ? from_key(r_top) : '0;
        o_rsp.entry_count = COUNT_W'(r_cnt);
    end

    // A response is only shown once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("response strobe while sequencer active");

    // The entry count never passes the heap depth.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A pop of an empty heap is refused in the following cycle.
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.mode == MODE_POP) && (r_cnt == '0))
        |=> (o_done && (o_rsp.status == ST_EMPTY)))
        else $error("empty pop not refused");

    // A push into a full heap leaves the count unchanged.
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.mode == MODE_PUSH) && (r_cnt == CNT_W'(DEPTH)))
        |=> (o_done && (o_rsp.status == ST_FULL) && (r_cnt == CNT_W'(DEPTH))))
        else $error("full push not refused");

endmodule

/* bench/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mhpq_pkg::*;

    // The fourth mode value has no name in the package. The block treats it
    // as a no-op that simply reports the current heap.
    localparam logic [1:0] MODE_NOP = 2'd3;

    // Least number of random requests after the directed opening.
    localparam int RANDOM_REQUESTS = 950;

    // The limit below must cover a run of roughly 1100 requests, each taking
    // the longest busy time of the block plus the longest sender gap.
    localparam int CYCLE_LIMIT = 200000;

    // Cycles to wait after the last response, so that any stray response
    // is still caught.
    localparam int DRAIN_CYCLES = 20;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_start = 1'b0;
    t_req     i_req   = '0;
    logic     o_busy;
    logic     o_done;
    t_rsp     o_rsp;

    min_heap_priority_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // Requests waiting to be driven, and responses predicted for requests
    // that the block has already accepted. The predicted responses are kept
    // oldest first.
    t_req req_backlog[$];
    t_rsp rsp_expected[$];

    // The bench keeps its own copy of the heap. Only entries below heap_fill
    // are ever read, so the unwritten contents never matter.
    t_key heap_keys [DEPTH];
    int   heap_fill = 0;

    // The generator tracks the fill level it expects, so that it can steer
    // request sequences toward a full heap or an empty one.
    int   gen_fill = 0;

    int   err_count   = 0;
    int   cycle_count = 0;
    int   burst_left  = 0;
    int   gap_left    = 0;
    t_rsp rsp_pred;
    t_rsp rsp_want;

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // Apply one accepted request to the bench's copy of the heap. It then
    // returns the response that the block has to produce.
    task automatic heap_apply(input t_req rq, output t_rsp rs);
        int   pos;
        int   parent;
        int   child;
        int   n;
        t_key moving;
        t_key tmp;
        rs        = '0;
        rs.status = ST_DONE;
        case (rq.mode)
            MODE_PUSH: begin
                if (heap_fill >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    // Append the key, then lift it past every parent that
                    // is not smaller. Equal parents are passed as well.
                    moving = t_key'(rq.value);
                    pos    = heap_fill;
                    heap_fill++;
                    while (pos > 0) begin
                        parent = (pos - 1) / 2;
                        if (moving > heap_keys[parent]) break;
                        heap_keys[pos] = heap_keys[parent];
                        pos = parent;
                    end
                    heap_keys[pos] = moving;
                end
            end
            MODE_POP: begin
                if (heap_fill == 0) begin
                    rs.status = ST_EMPTY;
                end else begin
                    // Swap the root with the last entry and drop the last
                    // entry. Then sink the new root. The right child is
                    // taken only when it is strictly smaller, and the walk
                    // stops on equality.
                    tmp                      = heap_keys[0];
                    heap_keys[0]             = heap_keys[heap_fill - 1];
                    heap_keys[heap_fill - 1] = tmp;
                    heap_fill--;
                    n = heap_fill;
                    if (n > 1) begin
                        pos    = 0;
                        child  = 1;
                        moving = heap_keys[0];
                        while (child < n) begin
                            if (child + 1 < n && heap_keys[child] > heap_keys[child + 1])
                                child++;
                            if (!(moving > heap_keys[child])) break;
                            heap_keys[pos] = heap_keys[child];
                            pos   = child;
                            child = 2 * child + 1;
                        end
                        heap_keys[pos] = moving;
                    end
                end
            end
            MODE_CLEAR: begin
                heap_fill = 0;
            end
            default: begin
                // A no-op request leaves the heap untouched.
            end
        endcase
        if (heap_fill > 0) begin
            rs.top_value = heap_keys[0];
            rs.top_valid = 1'b1;
        end
        rs.entry_count = COUNT_W'(heap_fill);
    endtask

    task automatic queue_request(input logic [1:0] m, input logic signed [VALUE_W-1:0] v);
        t_req rq;
        rq.mode  = m;
        rq.value = v;
        req_backlog.push_back(rq);
        case (m)
            MODE_PUSH:  if (gen_fill < DEPTH) gen_fill++;
            MODE_POP:   if (gen_fill > 0) gen_fill--;
            MODE_CLEAR: gen_fill = 0;
            default:    ;
        endcase
    endtask

    // Keys are mostly full-range random values. Some are the extremes, and
    // some come from a narrow band around zero so that equal keys are common.
    function automatic logic signed [VALUE_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            case ($urandom_range(0, 3))
                0:       return {1'b1, {(VALUE_W-1){1'b0}}};
                1:       return {1'b0, {(VALUE_W-1){1'b1}}};
                2:       return '0;
                default: return '1;
            endcase
        end else if (sel < 30) begin
            return $signed($urandom_range(0, 8)) - 4;
        end
        return $urandom;
    endfunction

    // Choose a mode for a mixed sequence. Pushes lead slightly, so that the
    // heap grows deep enough for multi-level sifts.
    function automatic logic [1:0] pick_mode(input int push_pct);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < push_pct)  return MODE_PUSH;
        if (sel < 94)        return MODE_POP;
        if (sel < 97)        return MODE_NOP;
        return MODE_CLEAR;
    endfunction

    // Request source. It runs bursts of random length with random gaps
    // between them. A gap of zero gives long stretches of back-to-back
    // requests. A request stays on the bus until the block takes it.
    // Each accepted request is predicted right away, so the expectations
    // line up in the order that the block serves them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                heap_apply(i_req, rsp_pred);
                rsp_expected.push_back(rsp_pred);
            end
            if (i_start && o_busy) begin
                // The block is still busy, so the request is held as is.
            end else if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (req_backlog.size() > 0) begin
                i_req   <= req_backlog.pop_front();
                i_start <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Response checker. A response is valid for one cycle only, and it is
    // compared with the oldest prediction on the edge that ends that cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                if (err_count < 10)
                    $display("[%0t] unexpected response: status %0d top %0d valid %0b count %0d",
                             $realtime, o_rsp.status, o_rsp.top_value, o_rsp.top_valid,
                             o_rsp.entry_count);
                err_count++;
            end else begin
                rsp_want = rsp_expected.pop_front();
                if (o_rsp.status !== rsp_want.status ||
                    o_rsp.top_value !== rsp_want.top_value ||
                    o_rsp.top_valid !== rsp_want.top_valid ||
                    o_rsp.entry_count !== rsp_want.entry_count) begin
                    if (err_count < 10) begin
                        $display("[%0t] mismatch: expected status %0d top %0d valid %0b count %0d",
                                 $realtime, rsp_want.status, rsp_want.top_value,
                                 rsp_want.top_valid, rsp_want.entry_count);
                        $display("[%0t]           got status %0d top %0d valid %0b count %0d",
                                 $realtime, o_rsp.status, o_rsp.top_value,
                                 o_rsp.top_valid, o_rsp.entry_count);
                    end
                    err_count++;
                end
            end
        end
    end

    // A hung block would otherwise stall the run forever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int generated;
        int run_len;
        int target;

        // Directed opening. It covers a pop on an empty heap, the key
        // extremes, equal keys, the no-op mode, a clear with entries and
        // without them, and draining to empty.
        queue_request(MODE_POP, '0);
        queue_request(MODE_PUSH, 32'sh7fff_ffff);
        queue_request(MODE_PUSH, 32'sh8000_0000);
        queue_request(MODE_PUSH, '0);
        queue_request(MODE_PUSH, -32'sd1);
        queue_request(MODE_PUSH, 32'sd5);
        queue_request(MODE_PUSH, 32'sd5);
        queue_request(MODE_PUSH, 32'sd5);
        queue_request(MODE_NOP, $urandom);
        queue_request(MODE_POP, $urandom);
        queue_request(MODE_POP, '0);
        queue_request(MODE_POP, '0);
        queue_request(MODE_POP, '0);
        queue_request(MODE_CLEAR, $urandom);
        queue_request(MODE_POP, '0);
        queue_request(MODE_CLEAR, '0);
        queue_request(MODE_PUSH, 32'sd1);
        queue_request(MODE_PUSH, -32'sd2);
        queue_request(MODE_PUSH, 32'sd3);
        queue_request(MODE_POP, '0);
        queue_request(MODE_NOP, '1);
        queue_request(MODE_POP, '0);
        queue_request(MODE_POP, '0);
        queue_request(MODE_POP, '0);

        // Random part, built from phases. Mixed runs exercise deep sifts.
        // Fill phases drive the heap to full and past it, drain phases
        // mostly pop, one or two past its fill; short clears reset it.
        generated = 0;
        while (generated < RANDOM_REQUESTS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    run_len = $urandom_range(10, 40);
                    repeat (run_len) queue_request(pick_mode(55), pick_key());
                    generated += run_len;
                end
                4, 5: begin
                    target = DEPTH + $urandom_range(1, 3) - gen_fill;
                    repeat (target) queue_request(MODE_PUSH, pick_key());
                    generated += target;
                end
                6, 7: begin
                    target = gen_fill + $urandom_range(1, 2);
                    repeat (target) begin
                        if ($urandom_range(0, 7) == 0)
                            queue_request(MODE_PUSH, pick_key());
                        else
                            queue_request(MODE_POP, $urandom);
                    end
                    generated += target;
                end
                8: begin
                    queue_request(MODE_CLEAR, $urandom);
                    queue_request(pick_mode(50), pick_key());
                    generated += 2;
                end
                default: begin
                    // Pushes from a tiny key range, mixed with pops, make
                    // equal keys the rule and test the tie handling.
                    run_len = $urandom_range(10, 30);
                    repeat (run_len) begin
                        if ($urandom_range(0, 99) < 60)
                            queue_request(MODE_PUSH, $signed($urandom_range(0, 3)));
                        else
                            queue_request(MODE_POP, $urandom);
                    end
                    generated += run_len;
                end
            endcase
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() > 0 || i_start || rsp_expected.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && rsp_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
design/mhpq_pkg.sv
design/mhpq_ram.sv
design/min_heap_priority_queue.sv
bench/tb.sv
